/* rtl/core/remote_frame_decoder_macros.svh */
// assertion macros for the remote frame decoder checker
`ifndef REMOTE_FRAME_DECODER_MACROS_SVH
`define REMOTE_FRAME_DECODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define RFD_ASSERT_NOW(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("remote frame decoder check failed");

// next-cycle implication, disabled in reset
`define RFD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("remote frame decoder check failed");

`endif

/* rtl/core/rfd_pkg.sv */
// shared types and constants for the remote frame decoder
`default_nettype none

package rfd_pkg;

    localparam int WINDOW_BYTES_DEF = 14;
    localparam int PACKET_BYTES     = 7;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 56;

    localparam logic [7:0] HDR_BYTE        = 8'hFF;
    localparam logic [7:0] REPLY_HDR       = 8'hFE;
    localparam logic [7:0] REPLY_KIND      = 8'h02;
    localparam logic [7:0] CMD_STATUS      = 8'h01;
    localparam logic [7:0] CMD_ATTITUDE    = 8'h02;
    localparam logic [7:0] CMD_STUNT       = 8'h03;
    localparam logic [7:0] STATUS_YAW_ZERO = 8'h02;
    localparam logic [7:0] STUNT_MIN_RST   = 8'd50;
    localparam logic [3:0] LAST_REPLY_WORD = 4'd15;

    typedef struct packed {
        logic [7:0] cmd;
        logic [7:0] arg0;
        logic [7:0] arg1;
        logic [7:0] arg2;
        logic [7:0] arg3;
    } pkt_t;

    typedef struct packed {
        logic done;
        logic found;
        pkt_t pkt;
    } scan_res_t;

endpackage

`default_nettype wire

/* rtl/core/remote_frame_decoder.sv */
// remote frame decoder top level: byte window, command decode and reply frames
//
// channel   dir  signals                     content
// s_*       in   s_tvalid s_tready s_tdata   one received byte with link flags
// m_*       out  m_tvalid m_tready m_tdata   result word, tuser = tx_valid
//                m_tuser m_tlast
// cfg_*     in   cfg_valid cfg_ready cfg_data stunt throttle minimum
//
// a byte that does not fill the window: taken in, then 1 result word
// a byte that fills it: taken in, then a scan of every start position
//   through one ram read port and the shared sum adder, then 1 or 16 result words
// s_tready is low from an accepted byte until its last result word is taken
// reset clears the stored commands and flags; the window ram needs no clear
`default_nettype none

module remote_frame_decoder #(
    parameter int WINDOW_BYTES = rfd_pkg::WINDOW_BYTES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rfd_pkg::S_TDATA_W-1:0] s_tdata,   // rx_byte, link_lost, clear_flags
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rfd_pkg::M_TDATA_W-1:0] m_tdata,   // tx_byte, throttle, pitch, roll,
                                                     // yaw, vehicle_status, stunt_request,
                                                     // yaw_zero_request
    output logic                          m_tuser,   // tx_valid
    output logic                          m_tlast,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [7:0]                    cfg_data
);

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam logic [AW-1:0] LAST_CNT = AW'(WINDOW_BYTES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_OUT
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] cnt_reg;
    logic          reply_reg;
    logic [3:0]    word_reg;
    logic          lost_reg;
    logic [7:0]    throttle_reg;
    logic [7:0]    pitch_reg;
    logic [7:0]    roll_reg;
    logic [7:0]    yaw_reg;
    logic [7:0]    status_reg;
    logic          stunt_reg;
    logic          yaw_zero_reg;
    logic [7:0]    min_reg;

    logic          s_accept;
    logic          scan_start;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    rd_data;
    logic [7:0]    tx_byte;
    logic [7:0]    reply_sum;
    rfd_pkg::scan_res_t scan_res;

    assign s_tready   = (state_reg == ST_IDLE);
    assign s_accept   = s_tvalid && s_tready;
    assign scan_start = s_accept && (cnt_reg == LAST_CNT);
    assign cfg_ready  = 1'b1;

    rfd_ram #(
        .WIDTH (8),
        .DEPTH (WINDOW_BYTES)
    ) u_rfd_ram (
        .clk     (clk),
        .wr_en   (s_accept),
        .wr_addr (cnt_reg),
        .wr_data (s_tdata[7:0]),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rfd_scan #(
        .WINDOW_BYTES (WINDOW_BYTES)
    ) u_rfd_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (scan_start),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .res     (scan_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            reply_reg    <= 1'b0;
            word_reg     <= '0;
            lost_reg     <= 1'b0;
            throttle_reg <= '0;
            pitch_reg    <= '0;
            roll_reg     <= '0;
            yaw_reg      <= '0;
            status_reg   <= '0;
            stunt_reg    <= 1'b0;
            yaw_zero_reg <= 1'b0;
            min_reg      <= rfd_pkg::STUNT_MIN_RST;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_reg <= cfg_data;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        if (s_tdata[9])
                        begin
                            stunt_reg    <= 1'b0;
                            yaw_zero_reg <= 1'b0;
                        end
                        lost_reg  <= s_tdata[8];
                        reply_reg <= 1'b0;
                        word_reg  <= '0;
                        if (cnt_reg == LAST_CNT)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= ST_SCAN;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + AW'(1);
                            state_reg <= ST_OUT;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_res.done)
                    begin
                        state_reg <= ST_OUT;
                        if (scan_res.found)
                        begin
                            case (scan_res.pkt.cmd)
                                rfd_pkg::CMD_STATUS:
                                begin
                                    status_reg <= scan_res.pkt.arg0;
                                    if (scan_res.pkt.arg0 == rfd_pkg::STATUS_YAW_ZERO)
                                    begin
                                        yaw_zero_reg <= 1'b1;
                                    end
                                    reply_reg <= 1'b1;
                                end
                                rfd_pkg::CMD_ATTITUDE:
                                begin
                                    if (!lost_reg)
                                    begin
                                        throttle_reg <= scan_res.pkt.arg0;
                                    end
                                    pitch_reg <= scan_res.pkt.arg1;
                                    roll_reg  <= scan_res.pkt.arg2;
                                    yaw_reg   <= scan_res.pkt.arg3;
                                end
                                rfd_pkg::CMD_STUNT:
                                begin
                                    if (throttle_reg >= min_reg)
                                    begin
                                        stunt_reg <= 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        if (!reply_reg || (word_reg == rfd_pkg::LAST_REPLY_WORD))
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            word_reg <= word_reg + 4'd1;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign reply_sum = 8'(rfd_pkg::REPLY_HDR + rfd_pkg::REPLY_KIND + status_reg);

    always_comb
    begin
        tx_byte = '0;
        if (reply_reg)
        begin
            case (word_reg[1:0])
                2'd0:    tx_byte = rfd_pkg::REPLY_HDR;
                2'd1:    tx_byte = rfd_pkg::REPLY_KIND;
                2'd2:    tx_byte = status_reg;
                default: tx_byte = reply_sum;
            endcase
        end
    end

    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser  = reply_reg;
    assign m_tlast  = !reply_reg || (word_reg == rfd_pkg::LAST_REPLY_WORD);
    assign m_tdata  = {6'b0, yaw_zero_reg, stunt_reg, status_reg, yaw_reg,
                       roll_reg, pitch_reg, throttle_reg, tx_byte};

endmodule

`default_nettype wire

/* rtl/core/rfd_ram.sv */
// generic single-write, single-read ram with registered read
`default_nettype none

module rfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/rfd_scan.sv */
// window scanner: walks start positions, checks header and byte sum with one adder
`default_nettype none

module rfd_scan #(
    parameter int WINDOW_BYTES = rfd_pkg::WINDOW_BYTES_DEF,
    localparam int AW = $clog2(WINDOW_BYTES)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                rd_en,
    output logic [AW-1:0]       rd_addr,
    input  logic [7:0]          rd_data,
    output rfd_pkg::scan_res_t  res
);

    localparam logic [AW-1:0] LAST_POS = AW'(WINDOW_BYTES - rfd_pkg::PACKET_BYTES);
    localparam logic [2:0]    LAST_OFF = 3'(rfd_pkg::PACKET_BYTES - 1);

    logic          run_reg;
    logic [AW-1:0] pos_reg;
    logic [2:0]    off_reg;
    logic          dv_reg;
    logic [2:0]    doff_reg;
    logic          dlast_reg;
    logic          done_reg;
    logic          found_reg;
    logic          hdr_ok_reg;
    logic [7:0]    sum_reg;
    logic [4:0][7:0] cand_reg;
    rfd_pkg::pkt_t pkt_reg;
    logic          issue_last;
    logic [7:0]    sum_next;
    logic          match;

    assign rd_en      = run_reg;
    assign rd_addr    = pos_reg + AW'(off_reg);
    assign issue_last = (pos_reg == LAST_POS) && (off_reg == LAST_OFF);
    assign sum_next   = (doff_reg == 3'd0) ? rd_data : 8'(sum_reg + rd_data);
    assign match      = dv_reg && (doff_reg == LAST_OFF) && hdr_ok_reg && (rd_data == sum_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg   <= 1'b0;
            pos_reg   <= '0;
            off_reg   <= '0;
            dv_reg    <= 1'b0;
            doff_reg  <= '0;
            dlast_reg <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            dv_reg    <= run_reg;
            doff_reg  <= off_reg;
            dlast_reg <= issue_last;
            done_reg  <= dv_reg && dlast_reg;
            if (start)
            begin
                run_reg   <= 1'b1;
                pos_reg   <= '0;
                off_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (run_reg)
                begin
                    if (off_reg == LAST_OFF)
                    begin
                        off_reg <= '0;
                        pos_reg <= pos_reg + AW'(1);
                    end
                    else
                    begin
                        off_reg <= off_reg + 3'd1;
                    end
                    if (issue_last)
                    begin
                        run_reg <= 1'b0;
                    end
                end
                if (match)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // payload: running sum, header check and candidate bytes
    always_ff @(posedge clk)
    begin
        if (dv_reg)
        begin
            sum_reg <= sum_next;
            case (doff_reg)
                3'd0:    hdr_ok_reg  <= (rd_data == rfd_pkg::HDR_BYTE);
                3'd1:    cand_reg[0] <= rd_data;
                3'd2:    cand_reg[1] <= rd_data;
                3'd3:    cand_reg[2] <= rd_data;
                3'd4:    cand_reg[3] <= rd_data;
                3'd5:    cand_reg[4] <= rd_data;
                default: ;
            endcase
        end
        // later match overwrites, last one wins
        if (match)
        begin
            pkt_reg.cmd  <= cand_reg[0];
            pkt_reg.arg0 <= cand_reg[1];
            pkt_reg.arg1 <= cand_reg[2];
            pkt_reg.arg2 <= cand_reg[3];
            pkt_reg.arg3 <= cand_reg[4];
        end
    end

    assign res.done  = done_reg;
    assign res.found = found_reg;
    assign res.pkt   = pkt_reg;

endmodule

`default_nettype wire

/* rtl/core/rfd_checker.sv */
// port-level checker for the remote frame decoder, with its bind
`default_nettype none

`include "remote_frame_decoder_macros.svh"

module rfd_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [rfd_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tuser,
    input wire logic                          m_tlast
);

    // no new byte while a result word is pending
    `RFD_ASSERT_NOW(a_no_accept_while_out, clk, rst_n, m_tvalid, !s_tready)
    // a byte is worked one at a time
    `RFD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // a word without a reply byte stands alone
    `RFD_ASSERT_NOW(a_noreply_is_last, clk, rst_n, m_tvalid && !m_tuser,
                    m_tlast && (m_tdata[7:0] == 8'h00))
    // after the last word the output side goes quiet
    `RFD_ASSERT_NEXT(a_quiet_after_last, clk, rst_n, m_tvalid && m_tready && m_tlast,
                     !m_tvalid)
    // a stalled word holds
    `RFD_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind remote_frame_decoder rfd_checker u_rfd_checker (.*);

`default_nettype wire

/* sim/testbench.sv */
// self-checking testbench for the remote frame decoder
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic       yaw_zero_request;
        logic       stunt_request;
        logic [7:0] vehicle_status;
        logic [7:0] yaw;
        logic [7:0] roll;
        logic [7:0] pitch;
        logic [7:0] throttle;
        logic [7:0] tx_byte;
    } state_word_t;

    typedef struct packed {
        logic        tx_valid;
        logic        last;
        state_word_t body;
    } decoded_word_t;

    class decoder_shadow;
        logic [7:0]    window_mem [rfd_pkg::WINDOW_BYTES_DEF];
        int unsigned   fill;
        logic [7:0]    throttle, pitch, roll, yaw, status, stunt_min;
        logic          stunt, yaw_zero;
        decoded_word_t expected_words [$];
        int            errors, n_bytes, n_words, n_replies;
        int            cmd_seen [4];

        function new();
            fill = 0;
            throttle = 0;
            pitch = 0;
            roll = 0;
            yaw = 0;
            status = 0;
            stunt = 0;
            yaw_zero = 0;
            stunt_min = rfd_pkg::STUNT_MIN_RST;
            errors = 0;
            n_bytes = 0;
            n_words = 0;
            n_replies = 0;
            cmd_seen = '{0, 0, 0, 0};
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void push_word(logic [7:0] tx, logic valid, logic fin);
            decoded_word_t w;
            w.tx_valid = valid;
            w.last = fin;
            w.body = '{yaw_zero, stunt, status, yaw, roll, pitch, throttle, tx};
            expected_words.push_back(w);
        endfunction

        function void take_byte(logic [7:0] b, logic lost, logic clr);
            logic [7:0] sum;
            logic [7:0] cmd, a0, a1, a2, a3;
            logic [7:0] frame [4];
            bit         hit, reply;
            int         j, i, k;
            n_bytes++;
            reply = 0;
            hit = 0;
            if (clr)
            begin
                stunt = 0;
                yaw_zero = 0;
            end
            if (fill >= rfd_pkg::WINDOW_BYTES_DEF)
                fill = 0;
            window_mem[fill] = b;
            fill++;
            if (fill >= rfd_pkg::WINDOW_BYTES_DEF)
            begin
                fill = 0;
                for (j = 0; j + rfd_pkg::PACKET_BYTES <= rfd_pkg::WINDOW_BYTES_DEF; j++)
                begin
                    if (window_mem[j] == rfd_pkg::HDR_BYTE)
                    begin
                        sum = '0;
                        for (i = 0; i < rfd_pkg::PACKET_BYTES - 1; i++)
                            sum = sum + window_mem[j + i];
                        if (window_mem[j + rfd_pkg::PACKET_BYTES - 1] == sum)
                        begin
                            hit = 1;
                            cmd = window_mem[j + 1];
                            a0 = window_mem[j + 2];
                            a1 = window_mem[j + 3];
                            a2 = window_mem[j + 4];
                            a3 = window_mem[j + 5];
                        end
                    end
                end
                if (hit)
                begin
                    case (cmd)
                        rfd_pkg::CMD_STATUS:
                        begin
                            cmd_seen[1]++;
                            status = a0;
                            if (status == rfd_pkg::STATUS_YAW_ZERO)
                                yaw_zero = 1;
                            reply = 1;
                        end
                        rfd_pkg::CMD_ATTITUDE:
                        begin
                            cmd_seen[2]++;
                            if (!lost)
                                throttle = a0;
                            pitch = a1;
                            roll = a2;
                            yaw = a3;
                        end
                        rfd_pkg::CMD_STUNT:
                        begin
                            cmd_seen[3]++;
                            if (throttle >= stunt_min)
                                stunt = 1;
                        end
                        default:
                            cmd_seen[0]++;
                    endcase
                end
            end
            if (!reply)
                push_word(8'h00, 1'b0, 1'b1);
            else
            begin
                n_replies++;
                frame[0] = rfd_pkg::REPLY_HDR;
                frame[1] = rfd_pkg::REPLY_KIND;
                frame[2] = status;
                frame[3] = rfd_pkg::REPLY_HDR + rfd_pkg::REPLY_KIND + status;
                for (k = 0; k < 16; k++)
                    push_word(frame[k % 4], 1'b1, k == 15);
            end
        endfunction

        function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_word(logic [rfd_pkg::M_TDATA_W-1:0] data, logic user, logic lst);
            decoded_word_t want;
            state_word_t   got;
            n_words++;
            got = data[$bits(state_word_t)-1:0];
            if (expected_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, data);
                errors++;
                return;
            end
            want = expected_words.pop_front();
            cmp_field("tx_valid", 8'(want.tx_valid), 8'(user));
            cmp_field("last", 8'(want.last), 8'(lst));
            cmp_field("tx_byte", want.body.tx_byte, got.tx_byte);
            cmp_field("throttle", want.body.throttle, got.throttle);
            cmp_field("pitch", want.body.pitch, got.pitch);
            cmp_field("roll", want.body.roll, got.roll);
            cmp_field("yaw", want.body.yaw, got.yaw);
            cmp_field("vehicle_status", want.body.vehicle_status, got.vehicle_status);
            cmp_field("stunt_request", 8'(want.body.stunt_request),
                      8'(got.stunt_request));
            cmp_field("yaw_zero_request", 8'(want.body.yaw_zero_request),
                      8'(got.yaw_zero_request));
            cmp_field("pad", 8'h00, 8'(data[rfd_pkg::M_TDATA_W-1:$bits(state_word_t)]));
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [rfd_pkg::S_TDATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [rfd_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tuser;
    logic                          m_tlast;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [7:0]                    cfg_data;

    decoder_shadow shadow;
    int            src_idle_pct = 0;
    int            sink_stall_pct = 0;
    logic [7:0]    win_buf [rfd_pkg::WINDOW_BYTES_DEF];

    remote_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            shadow.check_word(m_tdata, m_tuser, m_tlast);

    initial
    begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    function void put_packet(int pos, logic [7:0] cmd, logic [7:0] a0, logic [7:0] a1,
                             logic [7:0] a2, logic [7:0] a3, bit corrupt);
        logic [7:0] sum;
        win_buf[pos] = rfd_pkg::HDR_BYTE;
        win_buf[pos + 1] = cmd;
        win_buf[pos + 2] = a0;
        win_buf[pos + 3] = a1;
        win_buf[pos + 4] = a2;
        win_buf[pos + 5] = a3;
        sum = rfd_pkg::HDR_BYTE + cmd + a0 + a1 + a2 + a3;
        win_buf[pos + 6] = corrupt ? sum + 8'(1 + $urandom_range(0, 254)) : sum;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic lost, input logic clr);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(rfd_pkg::S_TDATA_W - 10){1'b0}}, clr, lost, b};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        shadow.take_byte(b, lost, clr);
        @(negedge clk);
    endtask

    task automatic send_window(input int lost_pct, input int clr_pct);
        int i;
        for (i = 0; i < rfd_pkg::WINDOW_BYTES_DEF; i++)
            send_byte(win_buf[i], $urandom_range(0, 99) < lost_pct,
                      $urandom_range(0, 99) < clr_pct);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (shadow.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_stunt_min(input logic [7:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        shadow.stunt_min = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_window();
        int         i, n, pos, pick;
        logic [7:0] cmd, a0;
        for (i = 0; i < rfd_pkg::WINDOW_BYTES_DEF; i++)
            win_buf[i] = ($urandom_range(0, 7) == 0) ? rfd_pkg::HDR_BYTE : 8'($urandom);
        if ($urandom_range(0, 9) != 0)
        begin
            n = $urandom_range(1, 2);
            repeat (n)
            begin
                pos = $urandom_range(0, rfd_pkg::WINDOW_BYTES_DEF - rfd_pkg::PACKET_BYTES);
                pick = $urandom_range(0, 9);
                cmd = (pick < 3) ? rfd_pkg::CMD_STATUS : (pick < 6) ? rfd_pkg::CMD_ATTITUDE :
                      (pick < 9) ? rfd_pkg::CMD_STUNT : 8'($urandom);
                a0 = (cmd == rfd_pkg::CMD_STATUS && $urandom_range(0, 2) == 0) ?
                     rfd_pkg::STATUS_YAW_ZERO : 8'($urandom);
                put_packet(pos, cmd, a0, 8'($urandom), 8'($urandom), 8'($urandom),
                           $urandom_range(0, 5) == 0);
            end
        end
        send_window(30, 6);
    endtask

    initial
    begin
        int         p, w, i;
        logic [7:0] stunt_mins [8];
        shadow = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // attitude with full throttle, then a packet with a broken sum
        put_packet(0, rfd_pkg::CMD_ATTITUDE, 8'hFF, 8'h00, 8'h80, 8'h7F, 0);
        put_packet(7, rfd_pkg::CMD_STUNT, 8'h00, 8'h00, 8'h00, 8'h00, 1);
        send_window(0, 0);
        // stunt loses to a later status packet that asks for yaw zero
        put_packet(0, rfd_pkg::CMD_STUNT, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0);
        put_packet(7, rfd_pkg::CMD_STATUS, rfd_pkg::STATUS_YAW_ZERO, 8'h00, 8'hFF, 8'h00, 0);
        for (i = 0; i < rfd_pkg::WINDOW_BYTES_DEF; i++)
            send_byte(win_buf[i], 1'b1, i == 0);

        stunt_mins = '{8'd0, 8'd255, 8'd1, 8'($urandom), 8'd254, rfd_pkg::STUNT_MIN_RST,
                       8'($urandom), 8'd128};
        for (p = 0; p < 8; p++)
        begin
            write_stunt_min(stunt_mins[p]);
            case (p % 4)
                0:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct = 82;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct = 0;
                    sink_stall_pct = 82;
                end
                default:
                begin
                    src_idle_pct = 35;
                    sink_stall_pct = 35;
                end
            endcase
            for (w = 0; w < 3; w++)
                random_window();
        end

        drain();
        repeat (100) @(negedge clk);
        $display("%0d bytes sent, %0d words checked, %0d reply frames",
                 shadow.n_bytes, shadow.n_words, shadow.n_replies);
        $display("commands decoded: status %0d, attitude %0d, stunt %0d, unknown %0d",
                 shadow.cmd_seen[1], shadow.cmd_seen[2], shadow.cmd_seen[3],
                 shadow.cmd_seen[0]);
        if (shadow.errors == 0 && shadow.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* remote_frame_decoder.f */
+incdir+rtl/core
rtl/core/rfd_pkg.sv
rtl/core/rfd_ram.sv
rtl/core/rfd_scan.sv
rtl/core/remote_frame_decoder.sv
rtl/core/rfd_checker.sv
sim/testbench.sv
